// File: rtl/pso_pkg.sv
// ----------------------------------------------------------------------------
// pso_pkg
// Shared types, register codes and fixed-point constants of the particle
// swarm update engine.
// ----------------------------------------------------------------------------
package pso_pkg;

  localparam int NUM_PARTICLES  = 32;
  localparam int NUM_DIMENSIONS = 8;
  localparam int STORE_DEPTH    = 256;
  localparam int ADDR_W         = $clog2(STORE_DEPTH);
  localparam int ENTRY_COUNT    = (NUM_PARTICLES * NUM_DIMENSIONS < STORE_DEPTH) ?
                                  NUM_PARTICLES * NUM_DIMENSIONS : STORE_DEPTH;

  // stages between the store read and the store write
  localparam int PIPE_DEPTH = 10;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_INERTIA   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SOCIAL    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_COGNITIVE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_VEL_LIMIT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_MODE      = 3'd4;

  localparam logic [15:0] INERTIA_RESET   = 16'd2048;
  localparam logic [15:0] SOCIAL_RESET    = 16'd8192;
  localparam logic [15:0] COGNITIVE_RESET = 16'd6144;
  localparam logic [15:0] VEL_LIMIT_RESET = 16'd9830;

  localparam logic MODE_ZERO_FLOOR  = 1'b0;
  localparam logic MODE_LOWER_BOUND = 1'b1;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  localparam logic [1:0] HIT_NONE  = 2'd0;
  localparam logic [1:0] HIT_LOWER = 2'd1;
  localparam logic [1:0] HIT_UPPER = 2'd2;

  // unsigned divide by constants as multiply and shift, exact for 32-bit operands
  localparam logic [31:0] DIV100_MUL   = 32'h51EB851F;
  localparam int          DIV100_SHIFT = 37;
  localparam int          PCT_W        = 64 - DIV100_SHIFT;
  localparam logic [31:0] PCT_BIAS     = 32'd50;
  localparam logic [31:0] DIV10_MUL    = 32'hCCCCCCCD;
  localparam int          DIV10_SHIFT  = 35;
  localparam int          QUOT_W       = 64 - DIV10_SHIFT;

  localparam int STEP_W = 42;

  typedef struct packed {
    logic                     cmd;
    logic [ADDR_W-1:0]        entry_index;
    logic signed [31:0]       init_position;
    logic signed [31:0]       global_best;
    logic signed [31:0]       personal_best;
    logic [16:0]              rand_social;
    logic [16:0]              rand_cognitive;
    logic [30:0]              upper_bound;
    logic signed [31:0]       lower_bound;
  } pso_in_t;

  typedef struct packed {
    logic signed [31:0] new_position;
    logic signed [31:0] new_velocity;
    logic [1:0]         bound_hit;
    logic               step_limited;
  } pso_out_t;

  typedef struct packed {
    logic [15:0] inertia_weight;
    logic [15:0] social_weight;
    logic [15:0] cognitive_weight;
    logic [15:0] velocity_limit_fraction;
    logic        bound_mode;
  } pso_cfg_t;

  // per-stage bookkeeping that rides beside the datapath
  typedef struct packed {
    logic               valid;
    logic               load;
    logic               store;
    logic [ADDR_W-1:0]  idx;
    logic signed [31:0] init;
  } pso_tag_t;

  // handoff from the term pipeline to the move unit
  typedef struct packed {
    logic signed [STEP_W-1:0] step_sum;
    logic [30:0]              limit;
    logic signed [31:0]       position;
    logic [30:0]              upper;
    logic signed [31:0]       lower;
    logic [PCT_W-1:0]         floor_pos;
  } pso_step_t;

endpackage

// File: rtl/pso_ram.sv
// ----------------------------------------------------------------------------
// pso_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pso_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/pso_step_calc.sv
// ----------------------------------------------------------------------------
// pso_step_calc
// Six-stage term pipeline: inertia, social and cognitive terms with
// round-to-nearest after each product, their exact sum, the step limit and
// the 1% floor position.
// ----------------------------------------------------------------------------
module pso_step_calc (
  input  logic                clk,
  input  pso_pkg::pso_in_t    item,
  input  pso_pkg::pso_cfg_t   cfg,
  input  logic signed [31:0]  cur_pos,
  input  logic signed [31:0]  cur_vel,
  output pso_pkg::pso_step_t  step
);

  // stage 2
  logic signed [32:0] s2_gdiff, s2_pdiff;
  logic signed [31:0] s2_pos, s2_vel, s2_lower;
  logic [46:0]        s2_lim_prod;
  logic [31:0]        s2_up50;
  logic [16:0]        s2_rs, s2_rc;
  logic [30:0]        s2_upper;

  // stage 3
  logic signed [50:0] s3_prod_g, s3_prod_p;
  logic signed [47:0] s3_prod_w;
  logic [63:0]        s3_pct_prod;
  logic [30:0]        s3_limit, s3_upper;
  logic signed [31:0] s3_pos, s3_lower;

  // stage 4
  logic signed [34:0]          s4_tg, s4_tp;
  logic signed [35:0]          s4_iw;
  logic [pso_pkg::PCT_W-1:0]   s4_pct;
  logic [30:0]                 s4_limit, s4_upper;
  logic signed [31:0]          s4_pos, s4_lower;

  // stage 5
  logic signed [51:0]          s5_mg, s5_mp;
  logic signed [35:0]          s5_iw;
  logic [pso_pkg::PCT_W-1:0]   s5_pct;
  logic [30:0]                 s5_limit, s5_upper;
  logic signed [31:0]          s5_pos, s5_lower;

  // stage 6
  logic signed [39:0]          s6_sg, s6_sp;
  logic signed [35:0]          s6_iw;
  logic [pso_pkg::PCT_W-1:0]   s6_pct;
  logic [30:0]                 s6_limit, s6_upper;
  logic signed [31:0]          s6_pos, s6_lower;

  logic [46:0]        lim_round;
  logic signed [50:0] g_round, p_round;
  logic signed [47:0] w_round;
  logic signed [51:0] mg_round, mp_round;

  always_comb begin
    lim_round = s2_lim_prod + 47'(1 << 15);
    g_round   = s3_prod_g + 51'(1 << 15);
    p_round   = s3_prod_p + 51'(1 << 15);
    w_round   = s3_prod_w + 48'(1 << 11);
    mg_round  = s5_mg + 52'(1 << 11);
    mp_round  = s5_mp + 52'(1 << 11);
  end

  always_ff @(posedge clk) begin
    // differences to the attractors, limit and floor products
    s2_gdiff    <= 33'($signed(item.global_best)) - 33'(cur_pos);
    s2_pdiff    <= 33'($signed(item.personal_best)) - 33'(cur_pos);
    s2_pos      <= cur_pos;
    s2_vel      <= cur_vel;
    s2_lim_prod <= 47'(item.upper_bound) * 47'(cfg.velocity_limit_fraction);
    s2_up50     <= 32'(item.upper_bound) + pso_pkg::PCT_BIAS;
    s2_rs       <= item.rand_social;
    s2_rc       <= item.rand_cognitive;
    s2_upper    <= item.upper_bound;
    s2_lower    <= $signed(item.lower_bound);

    s3_prod_g   <= 51'(s2_gdiff) * 51'($signed({1'b0, s2_rs}));
    s3_prod_p   <= 51'(s2_pdiff) * 51'($signed({1'b0, s2_rc}));
    s3_prod_w   <= 48'($signed({1'b0, cfg.inertia_weight})) * 48'(s2_vel);
    s3_pct_prod <= 64'(s2_up50) * 64'(pso_pkg::DIV100_MUL);
    s3_limit    <= lim_round[46:16];
    s3_upper    <= s2_upper;
    s3_pos      <= s2_pos;
    s3_lower    <= s2_lower;

    s4_tg       <= g_round[50:16];
    s4_tp       <= p_round[50:16];
    s4_iw       <= w_round[47:12];
    s4_pct      <= s3_pct_prod[63:pso_pkg::DIV100_SHIFT];
    s4_limit    <= s3_limit;
    s4_upper    <= s3_upper;
    s4_pos      <= s3_pos;
    s4_lower    <= s3_lower;

    s5_mg       <= 52'(s4_tg) * 52'($signed({1'b0, cfg.social_weight}));
    s5_mp       <= 52'(s4_tp) * 52'($signed({1'b0, cfg.cognitive_weight}));
    s5_iw       <= s4_iw;
    s5_pct      <= s4_pct;
    s5_limit    <= s4_limit;
    s5_upper    <= s4_upper;
    s5_pos      <= s4_pos;
    s5_lower    <= s4_lower;

    s6_sg       <= mg_round[51:12];
    s6_sp       <= mp_round[51:12];
    s6_iw       <= s5_iw;
    s6_pct      <= s5_pct;
    s6_limit    <= s5_limit;
    s6_upper    <= s5_upper;
    s6_pos      <= s5_pos;
    s6_lower    <= s5_lower;

    step.step_sum  <= pso_pkg::STEP_W'(s6_sg) + pso_pkg::STEP_W'(s6_sp)
                    + pso_pkg::STEP_W'(s6_iw);
    step.limit     <= s6_limit;
    step.position  <= s6_pos;
    step.upper     <= s6_upper;
    step.lower     <= s6_lower;
    step.floor_pos <= s6_pct;
  end

endmodule

// File: rtl/pso_move_unit.sv
// ----------------------------------------------------------------------------
// pso_move_unit
// Clamps the step, moves the position, tests both bounds and forms the
// reflected velocity -step/10 through a reciprocal multiply.
// ----------------------------------------------------------------------------
module pso_move_unit (
  input  logic               clk,
  input  pso_pkg::pso_step_t step,
  input  pso_pkg::pso_cfg_t  cfg,
  output pso_pkg::pso_out_t  res
);

  // stage 8
  logic signed [31:0]        s8_step, s8_pos, s8_lower;
  logic                      s8_limited;
  logic [30:0]               s8_upper;
  logic [pso_pkg::PCT_W-1:0] s8_pct;

  // stage 9
  logic signed [31:0] s9_moved, s9_step, s9_bound_pos;
  logic [31:0]        s9_u;
  logic               s9_neg, s9_limited;
  logic [1:0]         s9_hit;

  // stage 10
  logic [pso_pkg::QUOT_W-1:0] s10_q;
  logic signed [31:0]         s10_moved, s10_step, s10_bound_pos;
  logic                       s10_neg, s10_limited;
  logic [1:0]                 s10_hit;

  logic signed [pso_pkg::STEP_W-1:0] lim_wide;
  logic signed [31:0]                lim32, clamped;
  logic                              limited;
  logic signed [32:0]                moved, low_edge, upper_wide, u_pos, u_neg;
  logic                              step_le5;
  logic [1:0]                        hit;
  logic signed [31:0]                bound_pos;
  logic [63:0]                       q_prod;
  logic signed [31:0]                q32, refl;

  always_comb begin
    lim_wide = $signed(pso_pkg::STEP_W'(step.limit));
    lim32    = $signed({1'b0, step.limit});
    priority if (step.step_sum > lim_wide) begin
      clamped = lim32;
      limited = 1'b1;
    end else if (step.step_sum < -lim_wide) begin
      clamped = -lim32;
      limited = 1'b1;
    end else begin
      clamped = $signed(step.step_sum[31:0]);
      limited = 1'b0;
    end
  end

  always_comb begin
    moved      = 33'(s8_pos) + 33'(s8_step);
    low_edge   = (cfg.bound_mode == pso_pkg::MODE_LOWER_BOUND) ? 33'(s8_lower) : '0;
    upper_wide = $signed(33'(s8_upper));
    // floor((5 - step) / 10) on a magnitude: negative side uses step + 4
    step_le5   = (s8_step <= 32'sd5);
    u_pos      = 33'sd5 - 33'(s8_step);
    u_neg      = 33'(s8_step) + 33'sd4;
    priority if (moved < low_edge) begin
      hit       = pso_pkg::HIT_LOWER;
      bound_pos = (cfg.bound_mode == pso_pkg::MODE_LOWER_BOUND) ? s8_lower :
                  $signed(32'(s8_pct));
    end else if (moved > upper_wide) begin
      hit       = pso_pkg::HIT_UPPER;
      bound_pos = $signed({1'b0, s8_upper});
    end else begin
      hit       = pso_pkg::HIT_NONE;
      bound_pos = '0;
    end
  end

  assign q_prod = 64'(s9_u) * 64'(pso_pkg::DIV10_MUL);

  always_ff @(posedge clk) begin
    s8_step       <= clamped;
    s8_limited    <= limited;
    s8_pos        <= step.position;
    s8_upper      <= step.upper;
    s8_lower      <= step.lower;
    s8_pct        <= step.floor_pos;

    s9_moved      <= $signed(moved[31:0]);
    s9_step       <= s8_step;
    s9_bound_pos  <= bound_pos;
    s9_u          <= step_le5 ? u_pos[31:0] : u_neg[31:0];
    s9_neg        <= !step_le5;
    s9_limited    <= s8_limited;
    s9_hit        <= hit;

    s10_q         <= q_prod[63:pso_pkg::DIV10_SHIFT];
    s10_moved     <= s9_moved;
    s10_step      <= s9_step;
    s10_bound_pos <= s9_bound_pos;
    s10_neg       <= s9_neg;
    s10_limited   <= s9_limited;
    s10_hit       <= s9_hit;
  end

  always_comb begin
    q32  = $signed(32'(s10_q));
    refl = s10_neg ? -q32 : q32;
    res.bound_hit    = s10_hit;
    res.step_limited = s10_limited;
    if (s10_hit == pso_pkg::HIT_NONE) begin
      res.new_position = s10_moved;
      res.new_velocity = s10_step;
    end else begin
      res.new_position = s10_bound_pos;
      res.new_velocity = refl;
    end
  end

endmodule

// File: rtl/pso_particle_update.sv
// ----------------------------------------------------------------------------
// pso_particle_update
// Particle swarm velocity and position update over a store of 256 entries.
// ----------------------------------------------------------------------------
//  channel   handshake                     payload
//  command   start / busy                  item   (pso_in_t)
//  result    done, one cycle, no stall     result (pso_out_t)
//  config    cfg_valid / cfg_ready         cfg_index, cfg_data
//
//  one word accepted per cycle while busy is low; result registered from the last stage
//  busy rises while an item for the same entry is among the 10 stages between
//  store read and store write, so a repeat entry waits for that store write
//  rst holds busy high, and in the cycle after; the store has no clearing pass
//  cfg_ready is always high; results cannot be held off by the receiver
// ----------------------------------------------------------------------------
module pso_particle_update (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  pso_pkg::pso_in_t                    item,
  output logic                                done,
  output pso_pkg::pso_out_t                   result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pso_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [pso_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int LAST = pso_pkg::PIPE_DEPTH - 1;

  pso_pkg::pso_cfg_t  cfg;
  pso_pkg::pso_tag_t  tag [pso_pkg::PIPE_DEPTH];
  pso_pkg::pso_tag_t  tag_in;
  pso_pkg::pso_in_t   item_q;
  pso_pkg::pso_step_t step;
  pso_pkg::pso_out_t  move_res, final_res;

  logic               boot, accept, conflict, wr_en, dup_write;
  logic [31:0]        rd_pos, rd_vel;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign busy      = boot || conflict;

  // interlock against an entry still on its way to the store
  always_comb begin
    conflict = 1'b0;
    for (int k = 0; k < pso_pkg::PIPE_DEPTH; k++) begin
      if (tag[k].valid && tag[k].store && tag[k].idx == item.entry_index) begin
        conflict = 1'b1;
      end
    end
  end

  always_comb begin
    tag_in.valid = accept;
    tag_in.load  = (item.cmd == pso_pkg::CMD_LOAD);
    tag_in.store = ({1'b0, item.entry_index} < (pso_pkg::ADDR_W + 1)'(pso_pkg::ENTRY_COUNT));
    tag_in.idx   = item.entry_index;
    tag_in.init  = $signed(item.init_position);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      boot <= 1'b1;
      for (int k = 0; k < pso_pkg::PIPE_DEPTH; k++) begin
        tag[k] <= '0;
      end
    end else begin
      boot   <= 1'b0;
      tag[0] <= tag_in;
      for (int k = 1; k < pso_pkg::PIPE_DEPTH; k++) begin
        tag[k] <= tag[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inertia_weight          <= pso_pkg::INERTIA_RESET;
      cfg.social_weight           <= pso_pkg::SOCIAL_RESET;
      cfg.cognitive_weight        <= pso_pkg::COGNITIVE_RESET;
      cfg.velocity_limit_fraction <= pso_pkg::VEL_LIMIT_RESET;
      cfg.bound_mode              <= pso_pkg::MODE_ZERO_FLOOR;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pso_pkg::CFG_INERTIA:   cfg.inertia_weight          <= cfg_data;
        pso_pkg::CFG_SOCIAL:    cfg.social_weight           <= cfg_data;
        pso_pkg::CFG_COGNITIVE: cfg.cognitive_weight        <= cfg_data;
        pso_pkg::CFG_VEL_LIMIT: cfg.velocity_limit_fraction <= cfg_data;
        pso_pkg::CFG_MODE:      cfg.bound_mode              <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pso_ram #(.WIDTH(32), .DEPTH(pso_pkg::STORE_DEPTH)) u_pos_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tag[LAST].idx),
    .wr_data (final_res.new_position),
    .rd_en   (accept),
    .rd_addr (item.entry_index),
    .rd_data (rd_pos)
  );

  pso_ram #(.WIDTH(32), .DEPTH(pso_pkg::STORE_DEPTH)) u_vel_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tag[LAST].idx),
    .wr_data (final_res.new_velocity),
    .rd_en   (accept),
    .rd_addr (item.entry_index),
    .rd_data (rd_vel)
  );

  pso_step_calc u_calc (
    .clk     (clk),
    .item    (item_q),
    .cfg     (cfg),
    .cur_pos ($signed(rd_pos)),
    .cur_vel ($signed(rd_vel)),
    .step    (step)
  );

  pso_move_unit u_move (
    .clk  (clk),
    .step (step),
    .cfg  (cfg),
    .res  (move_res)
  );

  always_comb begin
    wr_en = tag[LAST].valid && tag[LAST].store;
    priority if (!tag[LAST].store) begin
      final_res = '0;
    end else if (tag[LAST].load) begin
      final_res.new_position = tag[LAST].init;
      final_res.new_velocity = '0;
      final_res.bound_hit    = pso_pkg::HIT_NONE;
      final_res.step_limited = 1'b0;
    end else begin
      final_res = move_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tag[LAST].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tag[LAST].valid) begin
      result <= final_res;
    end
  end

  // two writes in flight to one entry would break the read-modify-write
  always_comb begin
    dup_write = 1'b0;
    for (int k = 1; k < pso_pkg::PIPE_DEPTH; k++) begin
      if (tag[0].valid && tag[0].store && tag[k].valid && tag[k].store &&
          tag[k].idx == tag[0].idx) begin
        dup_write = 1'b1;
      end
    end
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(pso_pkg::PIPE_DEPTH + 1) done)
    else $error("result did not follow accept at fixed latency");

  a_no_dup_write: assert property (@(posedge clk) disable iff (rst)
    !dup_write)
    else $error("two in-flight items target one entry");

  a_write_done: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> done)
    else $error("store write without a result word");

  a_hit_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.bound_hit != 2'd3))
    else $error("invalid bound hit code");

endmodule

// File: test/pso_particle_update_tb.sv
// ----------------------------------------------------------------------------
// pso_particle_update_tb
// Self-checking bench for the particle swarm update engine. A short table of
// directed words (extreme loads, limit edges, bound reflection in both modes,
// back-to-back repeats of one entry) runs first. It is followed by random
// phases under several register settings, with the sender idling at varied
// rates. Every accepted word is run through a local fixed-point predictor,
// and each result is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module pso_particle_update_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pso_pkg::*;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   start     = 1'b0;
  logic                   busy;
  pso_in_t                item      = '0;
  logic                   done;
  pso_out_t               result;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  pso_particle_update u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // local copy of the registers and the entry store
  pso_cfg_t          swarm_cfg = '{INERTIA_RESET, SOCIAL_RESET, COGNITIVE_RESET,
                                   VEL_LIMIT_RESET, MODE_ZERO_FLOOR};
  logic signed [31:0] pos_mem [STORE_DEPTH];
  logic signed [31:0] vel_mem [STORE_DEPTH];
  bit                 loaded  [STORE_DEPTH];

  // per-entry bounds used to build well-formed random words
  int                 dim_upper [STORE_DEPTH];
  int                 dim_lower [STORE_DEPTH];
  logic [ADDR_W-1:0]  recent_idx = '0;

  pso_out_t expected_q [$];
  int items_sent   = 0;
  int results_seen = 0;
  int errors       = 0;
  int n_load       = 0;
  int n_update     = 0;
  int n_low        = 0;
  int n_high       = 0;
  int n_limited    = 0;
  int n_reg        = 0;

  initial begin
    #2_000_000;
    $display("timeout with %0d words accepted, %0d results seen", items_sent, results_seen);
    $display("CHECK FAILED");
    $finish;
  end

  // round to nearest, ties up: floor((x + 2^(s-1)) / 2^s)
  function automatic longint round_shr(longint x, int s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  // -step/10 rounded to nearest, ties up
  function automatic longint reflect_vel(longint step);
    longint a;
    a = 5 - step;
    if (a >= 0)
      return a / 10;
    return -((-a + 9) / 10);
  endfunction

  function automatic longint pull(longint target, longint pos, longint frac, longint coef);
    return round_shr(round_shr((target - pos) * frac, 16) * coef, 12);
  endfunction

  function automatic pso_out_t compute_update(pso_in_t it);
    pso_out_t r;
    longint   p, v, step, lim, moved, up, lo;
    r = '0;
    if (it.entry_index >= ENTRY_COUNT)
      return r;
    if (it.cmd == CMD_LOAD) begin
      pos_mem[it.entry_index] = it.init_position;
      vel_mem[it.entry_index] = '0;
      loaded[it.entry_index]  = 1'b1;
      r.new_position = it.init_position;
      n_load++;
      return r;
    end
    n_update++;
    p  = longint'(pos_mem[it.entry_index]);
    v  = longint'(vel_mem[it.entry_index]);
    up = longint'(it.upper_bound);
    lo = (swarm_cfg.bound_mode == MODE_LOWER_BOUND) ? longint'($signed(it.lower_bound)) : 0;
    step = round_shr(longint'(swarm_cfg.inertia_weight) * v, 12)
         + pull(longint'($signed(it.global_best)), p, longint'(it.rand_social),
                longint'(swarm_cfg.social_weight))
         + pull(longint'($signed(it.personal_best)), p, longint'(it.rand_cognitive),
                longint'(swarm_cfg.cognitive_weight));
    lim = round_shr(up * longint'(swarm_cfg.velocity_limit_fraction), 16);
    if (step > lim) begin
      step = lim;
      r.step_limited = 1'b1;
    end else if (step < -lim) begin
      step = -lim;
      r.step_limited = 1'b1;
    end
    moved = p + step;
    // lower side is tested first, so lower above upper lands on lower
    if (moved < lo) begin
      p = (swarm_cfg.bound_mode == MODE_LOWER_BOUND) ? lo : (up + 50) / 100;
      v = reflect_vel(step);
      r.bound_hit = HIT_LOWER;
      n_low++;
    end else if (moved > up) begin
      p = up;
      v = reflect_vel(step);
      r.bound_hit = HIT_UPPER;
      n_high++;
    end else begin
      p = moved;
      v = step;
    end
    if (r.step_limited)
      n_limited++;
    pos_mem[it.entry_index] = p[31:0];
    vel_mem[it.entry_index] = v[31:0];
    r.new_position = p[31:0];
    r.new_velocity = v[31:0];
    return r;
  endfunction

  // directed table
  typedef struct {
    bit                     is_reg;
    logic [CFG_INDEX_W-1:0] reg_idx;
    logic [15:0]            reg_val;
    pso_in_t                it;
    bit                     typed;
    pso_out_t               want;
  } plan_row_t;

  plan_row_t plan [$];

  function automatic void plan_load(logic [ADDR_W-1:0] idx, logic [31:0] init);
    plan_row_t r;
    r.is_reg  = 1'b0;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.it      = '0;
    r.it.cmd  = CMD_LOAD;
    r.it.entry_index   = idx;
    r.it.init_position = init;
    r.typed   = 1'b1;
    r.want    = '0;
    r.want.new_position = init;
    plan.push_back(r);
  endfunction

  function automatic void plan_update(logic [ADDR_W-1:0] idx, logic [31:0] gbest,
                                      logic [31:0] pbest, logic [16:0] rs, logic [16:0] rc,
                                      logic [30:0] up, logic [31:0] lo);
    plan_row_t r;
    r.is_reg  = 1'b0;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.it      = '0;
    r.it.cmd  = CMD_UPDATE;
    r.it.entry_index    = idx;
    r.it.global_best    = gbest;
    r.it.personal_best  = pbest;
    r.it.rand_social    = rs;
    r.it.rand_cognitive = rc;
    r.it.upper_bound    = up;
    r.it.lower_bound    = lo;
    r.typed   = 1'b0;
    r.want    = '0;
    plan.push_back(r);
  endfunction

  function automatic void plan_reg(logic [CFG_INDEX_W-1:0] idx, logic [15:0] val);
    plan_row_t r;
    r.is_reg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    r.it      = '0;
    r.typed   = 1'b0;
    r.want    = '0;
    plan.push_back(r);
  endfunction

  function automatic pso_cfg_t pick_setting(int phase);
    pso_cfg_t s;
    case (phase)
      0: s = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, MODE_LOWER_BOUND};
      1: s = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, MODE_ZERO_FLOOR};
      2: s = '{INERTIA_RESET, SOCIAL_RESET, COGNITIVE_RESET, VEL_LIMIT_RESET, MODE_LOWER_BOUND};
      7: s = '{INERTIA_RESET, SOCIAL_RESET, COGNITIVE_RESET, VEL_LIMIT_RESET, MODE_ZERO_FLOOR};
      default: begin
        s.inertia_weight          = 16'($urandom_range(0, 8192));
        s.social_weight           = 16'($urandom_range(0, 12288));
        s.cognitive_weight        = 16'($urandom_range(0, 12288));
        s.velocity_limit_fraction = 16'($urandom_range(0, 65535));
        s.bound_mode              = 1'($urandom_range(0, 1));
      end
    endcase
    return s;
  endfunction

  function automatic pso_in_t gen_item();
    pso_in_t           it;
    logic [255:0]      raw;
    logic [ADDR_W-1:0] idx;
    int unsigned       span;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it  = raw[$bits(pso_in_t)-1:0];
    // revisit the last entry often so repeats hit the interlock
    if ($urandom_range(0, 99) < 30)
      idx = recent_idx;
    else
      idx = ADDR_W'($urandom_range(0, ENTRY_COUNT - 1));
    recent_idx     = idx;
    it.entry_index = idx;
    // most words are well formed, the rest keep their raw random bits
    if ($urandom_range(0, 99) >= 15) begin
      span = dim_upper[idx] - dim_lower[idx];
      it.cmd            = ($urandom_range(0, 99) < 10) ? CMD_LOAD : CMD_UPDATE;
      it.init_position  = dim_lower[idx] + int'($urandom_range(0, span));
      it.global_best    = dim_lower[idx] + int'($urandom_range(0, span));
      it.personal_best  = dim_lower[idx] + int'($urandom_range(0, span));
      it.rand_social    = 17'($urandom_range(0, 65536));
      it.rand_cognitive = 17'($urandom_range(0, 65536));
      it.upper_bound    = 31'(dim_upper[idx]);
      it.lower_bound    = dim_lower[idx];
    end
    // an entry is never updated before its first load
    if (!loaded[idx])
      it.cmd = CMD_LOAD;
    return it;
  endfunction

  // start is left high after the accept; the caller lowers it or sends again
  task automatic issue(input pso_in_t it, input bit use_typed, input pso_out_t typed);
    pso_out_t predicted;
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    predicted = compute_update(it);
    expected_q.push_back(use_typed ? typed : predicted);
    items_sent++;
  endtask

  task automatic settle();
    start <= 1'b0;
    wait (results_seen == items_sent);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_INERTIA:   swarm_cfg.inertia_weight          = val;
      CFG_SOCIAL:    swarm_cfg.social_weight           = val;
      CFG_COGNITIVE: swarm_cfg.cognitive_weight        = val;
      CFG_VEL_LIMIT: swarm_cfg.velocity_limit_fraction = val;
      CFG_MODE:      swarm_cfg.bound_mode              = val[0];
      default: ;
    endcase
    n_reg++;
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    pso_out_t want;
    if (!rst && done === 1'b1) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing expected, expected none, got %h",
                 $time, result);
      end else begin
        want = expected_q.pop_front();
        check_field("new_position", want.new_position, result.new_position);
        check_field("new_velocity", want.new_velocity, result.new_velocity);
        check_field("bound_hit", 32'(want.bound_hit), 32'(result.bound_hit));
        check_field("step_limited", 32'(want.step_limited), 32'(result.step_limited));
      end
    end
  end

  initial begin : stimulus
    pso_cfg_t setting;
    int       idle_pct;

    plan_load(8'd0, 32'h7FFF_FFFF);
    plan_load(8'd255, 32'h8000_0000);
    plan_load(8'd1, 32'd0);
    plan_load(8'd2, 32'd100000);
    plan_load(8'd3, 32'd100000);
    // step of twice the gap lands exactly on the limit, then just past it
    plan_update(8'd2, 32'd198300, 32'd0, 17'd65536, 17'd0, 31'd1310720, 32'd0);
    plan_update(8'd3, 32'd198301, 32'd0, 17'd65536, 17'd0, 31'd1310720, 32'd0);
    // largest position, fractions above one, widest bound
    plan_update(8'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 17'h1FFFF, 17'h1FFFF, 31'h7FFF_FFFF,
                32'h8000_0000);
    // most negative position drops below zero and resets to 1% of upper
    plan_update(8'd255, 32'h8000_0000, 32'h8000_0000, 17'd0, 17'd0, 31'd1000, 32'd0);
    // same entry back to back
    plan_update(8'd1, -32'sd1000, -32'sd1000, 17'd65536, 17'd65536, 31'h7FFF_FFFF, 32'd0);
    plan_update(8'd1, 32'd655360, 32'd0, 17'd40000, 17'd30000, 31'd2000000, 32'd0);
    plan_update(8'd1, 32'd0, 32'd900000, 17'd12345, 17'd65535, 31'd2000000, 32'd0);
    plan_reg(CFG_MODE, 16'(MODE_LOWER_BOUND));
    // lower above upper goes to lower
    plan_update(8'd2, 32'd0, 32'd0, 17'd65536, 17'd65536, 31'd1000000, 32'd5000000);
    plan_update(8'd3, -32'sd1000000, -32'sd1000000, 17'd65536, 17'd65536, 31'd2000000,
                -32'sd65536);
    // zero upper bound leaves no room to move
    plan_update(8'd0, 32'd0, 32'd0, 17'd65536, 17'd65536, 31'd0, 32'd0);
    plan_update(8'd255, 32'h7FFF_FFFF, 32'h8000_0000, 17'd65536, 17'h1FFFF, 31'h7FFF_FFFF,
                32'h8000_0000);
    plan_reg(CFG_MODE, 16'(MODE_ZERO_FLOOR));
    plan_update(8'd1, 32'hFFFF_FFFF, 32'h0000_0001, 17'h10000, 17'h0FFFF, 31'd65536,
                32'hFFFF_FFFF);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        settle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
        cfg_valid <= 1'b0;
      end else
        issue(plan[i].it, plan[i].typed, plan[i].want);
    end

    for (int phase = 0; phase < 8; phase++) begin
      settle();
      setting = pick_setting(phase);
      write_reg(CFG_INERTIA, setting.inertia_weight);
      write_reg(CFG_SOCIAL, setting.social_weight);
      write_reg(CFG_COGNITIVE, setting.cognitive_weight);
      write_reg(CFG_VEL_LIMIT, setting.velocity_limit_fraction);
      write_reg(CFG_MODE, 16'(setting.bound_mode));
      cfg_valid <= 1'b0;
      // fresh dimension bounds; a few are tiny so the 1% reset stays small
      for (int e = 0; e < STORE_DEPTH; e++) begin
        if ($urandom_range(0, 3) == 0)
          dim_upper[e] = $urandom_range(0, 1 << 12);
        else
          dim_upper[e] = $urandom_range(1 << 16, 1 << 26);
        dim_lower[e] = -int'($urandom_range(0, dim_upper[e]));
      end
      idle_pct = (phase < 3) ? 36 : (phase < 6) ? 61 : 0;
      for (int n = 0; n < 100; n++) begin
        issue(gen_item(), 1'b0, '0);
        if ($urandom_range(0, 49) == 0)
          settle();
        else
          while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
          end
      end
    end

    settle();
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    if (expected_q.size() != 0) begin
      errors += expected_q.size();
      $display("%0t: %0d expected results never arrived", $time, expected_q.size());
    end
    $display("%0d words (%0d loads, %0d updates) under %0d register writes",
             items_sent, n_load, n_update, n_reg);
    $display("updates hit lower %0d, upper %0d, step clamped %0d; %0d errors",
             n_low, n_high, n_limited, errors);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
